### hdl/tpfs_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the tangent point solver.
package tpfs_pkg;

  localparam logic signed [39:0] CORDIC_K      = 40'sd652032874;
  localparam logic signed [33:0] QUARTER_Z     = 34'sh0_4000_0000;
  localparam logic signed [33:0] HALF_Z        = 34'sh0_8000_0000;
  localparam logic [33:0]        QUARTER_TURN  = 34'h0_4000_0000;
  localparam logic [33:0]        THREE_QUARTER = 34'h0_C000_0000;
  localparam logic [63:0]        ONE_Q56       = 64'h0100_0000_0000_0000;
  localparam logic [34:0]        ONE_Q28_U     = 35'd268435456;
  localparam logic signed [41:0] ONE_Q28_S     = 42'sd268435456;
  localparam logic signed [35:0] ONE_Q28_D     = 36'sd268435456;

  typedef struct packed {
    logic signed [31:0] xi;
    logic signed [31:0] eta;
    logic [31:0]        ra;
    logic [34:0]        x2;
    logic [34:0]        y2;
  } side_a_t;

  typedef struct packed {
    logic signed [31:0] xi;
    logic signed [31:0] eta;
    logic [31:0]        ra;
    logic signed [35:0] sdf;
    logic               neg;
  } side_b_t;

  typedef struct packed {
    logic [31:0] ra;
    logic        neg;
    logic        one_only;
    logic [3:0]  zero;
  } side_c_t;

  typedef struct packed {
    logic signed [39:0] x;
    logic signed [39:0] y;
  } sc_t;

  function automatic logic [31:0] arctan_at(input int unsigned i);
    logic [31:0] a;
    case (i)
      0:  a = 32'h20000000;
      1:  a = 32'h12E4051E;
      2:  a = 32'h09FB385B;
      3:  a = 32'h051111D4;
      4:  a = 32'h028B0D43;
      5:  a = 32'h0145D7E1;
      6:  a = 32'h00A2F61E;
      7:  a = 32'h00517C55;
      8:  a = 32'h0028BE53;
      9:  a = 32'h00145F2F;
      10: a = 32'h000A2F98;
      11: a = 32'h000517CC;
      12: a = 32'h00028BE6;
      13: a = 32'h000145F3;
      14: a = 32'h0000A2F9;
      15: a = 32'h0000517D;
      16: a = 32'h000028BE;
      17: a = 32'h0000145F;
      18: a = 32'h00000A30;
      19: a = 32'h00000518;
      20: a = 32'h0000028C;
      21: a = 32'h00000146;
      22: a = 32'h000000A3;
      23: a = 32'h00000051;
      24: a = 32'h00000029;
      25: a = 32'h00000014;
      26: a = 32'h0000000A;
      27: a = 32'h00000005;
      28: a = 32'h00000003;
      29: a = 32'h00000001;
      30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

### hdl/tpfs_delay.sv
// Fixed-length delay line that keeps side data in step with the datapath.
module tpfs_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  generate
    if (DEPTH == 0) begin : g_none
      assign q = d;
    end else begin : g_line
      logic [W-1:0] pipe [DEPTH];
      always_ff @(posedge clk) begin
        pipe[0] <= d;
        for (int k = 1; k < DEPTH; k++) begin
          pipe[k] <= pipe[k-1];
        end
      end
      assign q = pipe[DEPTH-1];
    end
  endgenerate

endmodule

### hdl/tpfs_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module tpfs_sqrt_cell #(
  parameter int BIT = 31
) (
  input  logic        clk,
  input  logic [63:0] src_v,
  input  logic [63:0] src_res,
  output logic [63:0] v,
  output logic [63:0] res
);

  localparam logic [63:0] ONE_BIT = 64'd1 << (2 * BIT);

  logic [63:0] trial;

  assign trial = src_res + ONE_BIT;

  always_ff @(posedge clk) begin
    if (src_v >= trial) begin
      v   <= src_v - trial;
      res <= (src_res >> 1) + ONE_BIT;
    end else begin
      v   <= src_v;
      res <= src_res >> 1;
    end
  end

endmodule

### hdl/tpfs_cordic_cell.sv
// One micro-rotation cell of a CORDIC chain, in rotation or vectoring mode.
module tpfs_cordic_cell import tpfs_pkg::*; #(
  parameter int W     = 40,
  parameter int SHIFT = 0,
  parameter bit VEC   = 1'b0
) (
  input  logic                clk,
  input  logic signed [W-1:0] src_x,
  input  logic signed [W-1:0] src_y,
  input  logic [33:0]         src_z,
  output logic signed [W-1:0] x,
  output logic signed [W-1:0] y,
  output logic [33:0]         z
);

  logic signed [W-1:0] xs;
  logic signed [W-1:0] ys;
  logic [33:0]         ang;
  logic                pos;

  assign xs  = src_x >>> SHIFT;
  assign ys  = src_y >>> SHIFT;
  assign ang = {2'b00, arctan_at(SHIFT)};
  assign pos = VEC ? (src_y[W-1] || (src_y == '0)) : ~src_z[33];

  always_ff @(posedge clk) begin
    if (pos) begin
      x <= src_x - ys;
      y <= src_y + xs;
      z <= src_z - ang;
    end else begin
      x <= src_x + ys;
      y <= src_y - xs;
      z <= src_z + ang;
    end
  end

endmodule

### hdl/tangent_point_from_star_plane_coords_core.sv
// Top level of the pipelined tangent point solver for gnomonic projection.
//
//   channel | handshake     | beat contents
//   --------+---------------+-------------------------------------------------
//   input   | start, busy   | xi, eta, star_ra, star_dec
//   result  | done          | tp1_ra, tp1_dec, tp2_ra, tp2_dec, solution_count
//
// A new beat is taken in every cycle; busy is always low.
// Done rises once a beat has passed the sine/cosine chain, two 32-cell square root chains
// and the arctangent chains.
// Reset clears only the valid chain, so no result appears until a beat has passed through.
// Each result is shown for one cycle with done high; the receiver cannot stall.
module tangent_point_from_star_plane_coords_core import tpfs_pkg::*; #(
  parameter int CORDIC_STEPS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] xi,
  input  logic signed [31:0] eta,
  input  logic [31:0]        star_ra,
  input  logic signed [31:0] star_dec,
  output logic               done,
  output logic [31:0]        tp1_ra,
  output logic signed [31:0] tp1_dec,
  output logic [31:0]        tp2_ra,
  output logic signed [31:0] tp2_dec,
  output logic [1:0]         solution_count
);

  localparam int N  = CORDIC_STEPS;
  localparam int SQ = 32;
  localparam int QS = 1 + ((N > SQ + 1) ? N : SQ + 1);
  localparam int RS = QS + 4 + SQ;
  localparam int FS = RS + 4 + N;

  logic [FS:0] vld;

  logic signed [31:0] xi0, eta0, dec0;
  logic [31:0]        ra0;

  logic signed [63:0] xx1, yy1;
  logic signed [31:0] xi1, eta1;
  logic [31:0]        ra1;
  logic [33:0]        z1;
  logic               flip1;
  logic [33:0]        zd;

  logic [63:0] sum2;
  side_a_t     a2;

  logic signed [39:0] scx [0:N];
  logic signed [39:0] scy [0:N];
  logic [33:0]        scz [0:N];
  logic [63:0]        sv1 [0:SQ];
  logic [63:0]        sr1 [0:SQ];
  logic [63:0]        sv2 [0:SQ];
  logic [63:0]        sr2 [0:SQ];

  sc_t     sc_end, sc_q;
  logic    flip_q;
  logic [31:0] root_q;
  side_a_t a_q;

  logic signed [72:0] psr;
  logic signed [79:0] pcc, pss;
  logic               flip_m;
  side_a_t            a_m;

  logic signed [72:0] psn, sdf_t;
  logic signed [35:0] sdf_s;
  logic [31:0]        c2v, s2v;
  side_a_t            a_s;

  logic [66:0]        m1, m2;
  logic signed [35:0] sdf_p;
  side_a_t            a_p;

  logic signed [37:0] r2n, r2;
  side_b_t            b4, b_r;

  logic [31:0]        r_r;
  logic signed [64:0] pe;
  logic signed [67:0] pse;
  logic               degen;
  logic [31:0]        r5;
  side_b_t            b5;

  logic signed [64:0] fl, cl;
  logic signed [67:0] se, s1t, c1t, s2t, c2t;
  logic signed [41:0] rrw, nrw;

  logic signed [41:0] ly [4];
  logic signed [41:0] lx [4];
  logic [31:0]        ra6;
  logic signed [35:0] sdf6;
  logic               neg6;

  logic signed [57:0] px [4];
  logic signed [57:0] py [4];
  logic [33:0]        pz [4];
  logic [3:0]         zero_n;
  side_c_t            c7, c_end;

  logic signed [57:0] vx [0:3][0:N];
  logic signed [57:0] vy [0:3][0:N];
  logic [33:0]        vz [0:3][0:N];
  logic [31:0]        zf [4];

  assign busy = 1'b0;
  assign done = vld[FS];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[FS-1:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    xi0  <= xi;
    eta0 <= eta;
    ra0  <= star_ra;
    dec0 <= star_dec;
  end

  assign zd = {{2{dec0[31]}}, dec0};

  always_ff @(posedge clk) begin
    xx1  <= 64'(xi0) * 64'(xi0);
    yy1  <= 64'(eta0) * 64'(eta0);
    xi1  <= xi0;
    eta1 <= eta0;
    ra1  <= ra0;
    if ($signed(zd) > QUARTER_Z || $signed(zd) < -QUARTER_Z) begin
      z1    <= zd[33] ? zd + HALF_Z : zd - HALF_Z;
      flip1 <= 1'b1;
    end else begin
      z1    <= zd;
      flip1 <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    sum2  <= ONE_Q56 + xx1 + yy1;
    a2.xi <= xi1;
    a2.eta <= eta1;
    a2.ra <= ra1;
    a2.x2 <= xx1[62:28];
    a2.y2 <= yy1[62:28];
  end

  assign scx[0] = CORDIC_K;
  assign scy[0] = '0;
  assign scz[0] = z1;

  generate
    for (genvar k = 0; k < N; k++) begin : g_sc
      tpfs_cordic_cell #(.W(40), .SHIFT(k), .VEC(1'b0)) u_cell (
        .clk   (clk),
        .src_x (scx[k]),
        .src_y (scy[k]),
        .src_z (scz[k]),
        .x     (scx[k+1]),
        .y     (scy[k+1]),
        .z     (scz[k+1])
      );
    end
  endgenerate

  assign sv1[0] = sum2;
  assign sr1[0] = '0;
  assign sv2[0] = {r2[35:0], 28'b0};
  assign sr2[0] = '0;

  generate
    for (genvar k = 0; k < SQ; k++) begin : g_sq
      tpfs_sqrt_cell #(.BIT(SQ - 1 - k)) u_root1 (
        .clk     (clk),
        .src_v   (sv1[k]),
        .src_res (sr1[k]),
        .v       (sv1[k+1]),
        .res     (sr1[k+1])
      );
      tpfs_sqrt_cell #(.BIT(SQ - 1 - k)) u_root2 (
        .clk     (clk),
        .src_v   (sv2[k]),
        .src_res (sr2[k]),
        .v       (sv2[k+1]),
        .res     (sr2[k+1])
      );
    end
  endgenerate

  assign sc_end.x = scx[N];
  assign sc_end.y = scy[N];

  tpfs_delay #(.W($bits(sc_t)), .DEPTH(QS - 1 - N)) u_dly_sc (
    .clk (clk), .d (sc_end), .q (sc_q)
  );
  tpfs_delay #(.W(1), .DEPTH(QS - 1)) u_dly_flip (
    .clk (clk), .d (flip1), .q (flip_q)
  );
  tpfs_delay #(.W(32), .DEPTH(QS - 2 - SQ)) u_dly_root (
    .clk (clk), .d (sr1[SQ][31:0]), .q (root_q)
  );
  tpfs_delay #(.W($bits(side_a_t)), .DEPTH(QS - 2)) u_dly_a (
    .clk (clk), .d (a2), .q (a_q)
  );

  // Final sine and cosine stay within about one in Q2.30, so 32 bits carry them exactly.
  always_ff @(posedge clk) begin
    psr    <= 73'($signed(sc_q.y[31:0])) * 73'($signed({1'b0, root_q}));
    pcc    <= 80'($signed(sc_q.x[31:0])) * 80'($signed(sc_q.x[31:0]));
    pss    <= 80'($signed(sc_q.y[31:0])) * 80'($signed(sc_q.y[31:0]));
    flip_m <= flip_q;
    a_m    <= a_q;
  end

  always_comb begin
    psn   = flip_m ? -psr : psr;
    sdf_t = psn >>> 30;
  end

  always_ff @(posedge clk) begin
    sdf_s <= sdf_t[35:0];
    c2v   <= pcc[63:32];
    s2v   <= pss[63:32];
    a_s   <= a_m;
  end

  always_ff @(posedge clk) begin
    m1    <= 67'(c2v) * 67'(a_s.y2 + ONE_Q28_U);
    m2    <= 67'(s2v) * 67'(a_s.x2);
    sdf_p <= sdf_s;
    a_p   <= a_s;
  end

  assign r2n = $signed({2'b00, m1[63:28]}) - $signed({2'b00, m2[63:28]});

  always_ff @(posedge clk) begin
    r2     <= r2n;
    b4.xi  <= a_p.xi;
    b4.eta <= a_p.eta;
    b4.ra  <= a_p.ra;
    b4.sdf <= sdf_p;
    b4.neg <= r2n[37];
  end

  tpfs_delay #(.W($bits(side_b_t)), .DEPTH(SQ)) u_dly_b (
    .clk (clk), .d (b4), .q (b_r)
  );

  assign r_r = sr2[SQ][31:0];

  always_ff @(posedge clk) begin
    pe    <= 65'(b_r.eta) * 65'($signed({1'b0, r_r}));
    pse   <= 68'(b_r.sdf) * 68'(b_r.eta);
    degen <= (b_r.xi == '0) && (r_r == '0);
    r5    <= r_r;
    b5    <= b_r;
  end

  always_comb begin
    fl  = pe >>> 28;
    cl  = (pe + $signed(65'd268435455)) >>> 28;
    se  = pse >>> 28;
    rrw = degen ? ONE_Q28_S : $signed({10'b0, r5});
    nrw = -rrw;
    s1t = 68'(b5.sdf) - 68'(fl);
    c1t = se + 68'($signed({10'b0, r5}));
    s2t = degen ? 68'(b5.sdf) + 68'(b5.eta) : 68'(b5.sdf) + 68'(cl);
    c2t = se - 68'(rrw);
  end

  always_ff @(posedge clk) begin
    ly[0] <= 42'(b5.xi);
    lx[0] <= rrw;
    ly[1] <= s1t[41:0];
    lx[1] <= c1t[41:0];
    ly[2] <= 42'(b5.xi);
    lx[2] <= nrw;
    ly[3] <= s2t[41:0];
    lx[3] <= c2t[41:0];
    ra6   <= b5.ra;
    sdf6  <= b5.sdf;
    neg6  <= b5.neg;
  end

  generate
    for (genvar l = 0; l < 4; l++) begin : g_lane
      logic signed [57:0] sx, sy;

      assign sx = $signed({lx[l], 16'b0});
      assign sy = $signed({ly[l], 16'b0});
      assign zero_n[l] = (lx[l] == '0) && (ly[l] == '0);

      always_ff @(posedge clk) begin
        if (sx[57]) begin
          if (!sy[57]) begin
            px[l] <= sy;
            py[l] <= -sx;
            pz[l] <= QUARTER_TURN;
          end else begin
            px[l] <= -sy;
            py[l] <= sx;
            pz[l] <= THREE_QUARTER;
          end
        end else begin
          px[l] <= sx;
          py[l] <= sy;
          pz[l] <= '0;
        end
      end

      assign vx[l][0] = px[l];
      assign vy[l][0] = py[l];
      assign vz[l][0] = pz[l];

      for (genvar k = 0; k < N; k++) begin : g_vec
        tpfs_cordic_cell #(.W(58), .SHIFT(k), .VEC(1'b1)) u_cell (
          .clk   (clk),
          .src_x (vx[l][k]),
          .src_y (vy[l][k]),
          .src_z (vz[l][k]),
          .x     (vx[l][k+1]),
          .y     (vy[l][k+1]),
          .z     (vz[l][k+1])
        );
      end

      assign zf[l] = c_end.zero[l] ? 32'd0 : vz[l][N][31:0];
    end
  endgenerate

  always_ff @(posedge clk) begin
    c7.ra       <= ra6;
    c7.neg      <= neg6;
    c7.one_only <= (sdf6 < ONE_Q28_D) && (sdf6 > -ONE_Q28_D);
    c7.zero     <= zero_n;
  end

  tpfs_delay #(.W($bits(side_c_t)), .DEPTH(N)) u_dly_c (
    .clk (clk), .d (c7), .q (c_end)
  );

  always_ff @(posedge clk) begin
    if (c_end.neg) begin
      tp1_ra         <= '0;
      tp1_dec        <= '0;
      tp2_ra         <= '0;
      tp2_dec        <= '0;
      solution_count <= 2'd0;
    end else begin
      tp1_ra         <= c_end.ra - zf[0];
      tp1_dec        <= zf[1];
      tp2_ra         <= c_end.ra - zf[2];
      tp2_dec        <= zf[3];
      solution_count <= c_end.one_only ? 2'd1 : 2'd2;
    end
  end

endmodule

### test/tangent_point_from_star_plane_coords_core_tb.sv
// Self-checking testbench for the tangent point solver: directed table, then random beats.
module tangent_point_from_star_plane_coords_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STEPS = 32;
  localparam int LATENCY = 2 * ((STEPS > 33) ? STEPS : 33) + STEPS + 74;
  localparam int N_RANDOM = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam longint ONE_Q28 = 64'sd268435456;
  localparam longint GAIN = 64'sd652032874;
  localparam longint QTR = 64'sd1073741824;
  localparam longint HLF = 64'sd2147483648;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
    32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
    32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
    32'h00000001, 32'h00000000};

  typedef struct packed {
    logic [31:0] ra1;
    logic [31:0] dec1;
    logic [31:0] ra2;
    logic [31:0] dec2;
    logic [1:0]  cnt;
  } tangent_pts_t;

  typedef struct packed {
    logic [31:0]  xi;
    logic [31:0]  eta;
    logic [31:0]  ra;
    logic [31:0]  dec;
    logic         known;
    tangent_pts_t pts;
  } star_row_t;

  localparam tangent_pts_t NONE = '0;

  // Rows marked known have no real solution: every angle is zero and the count is zero.
  localparam star_row_t DIRECTED [20] = '{
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0, NONE},
    '{32'h7FFFFFFF, 32'h00000000, 32'h12345678, 32'h00000000, 1'b0, NONE},
    '{32'h80000000, 32'h00000000, 32'hFFFFFFFF, 32'h00000000, 1'b0, NONE},
    '{32'h00000000, 32'h7FFFFFFF, 32'h80000000, 32'h10000000, 1'b0, NONE},
    '{32'h00000000, 32'h80000000, 32'h00000001, 32'hF0000000, 1'b0, NONE},
    '{32'h10000000, 32'h00000000, 32'h00000000, 32'h40000000, 1'b1, NONE},
    '{32'hF0000000, 32'h00000000, 32'hAAAAAAAA, 32'hC0000000, 1'b1, NONE},
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h55555555, 32'h40000000, 1'b1, NONE},
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h40000000, 1'b0, NONE},
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'hC0000000, 1'b0, NONE},
    '{32'h00000000, 32'h08000000, 32'h01000000, 32'h40000000, 1'b0, NONE},
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h80000000, 1'b0, NONE},
    '{32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'h7FFFFFFF, 1'b0, NONE},
    '{32'h01000000, 32'hFF000000, 32'h40000000, 32'h60000000, 1'b0, NONE},
    '{32'hFF000000, 32'h01000000, 32'hC0000000, 32'hA0000000, 1'b0, NONE},
    '{32'h02000000, 32'h03000000, 32'h00000000, 32'h3F000000, 1'b0, NONE},
    '{32'h80000000, 32'h80000000, 32'hFFFFFFFF, 32'h80000000, 1'b0, NONE},
    '{32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h7FFFFFFF, 1'b0, NONE},
    '{32'h00000001, 32'hFFFFFFFF, 32'h00000000, 32'h20000000, 1'b0, NONE},
    '{32'h00000000, 32'h00000000, 32'h00000000, 32'h00000000, 1'b0, NONE}};

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] xi = '0;
  logic signed [31:0] eta = '0;
  logic [31:0]        star_ra = '0;
  logic signed [31:0] star_dec = '0;
  logic               done;
  logic [31:0]        tp1_ra;
  logic signed [31:0] tp1_dec;
  logic [31:0]        tp2_ra;
  logic signed [31:0] tp2_dec;
  logic [1:0]         solution_count;

  tangent_pts_t pending_pts[$];
  logic         cur_known = 1'b0;
  tangent_pts_t cur_pts = '0;
  int           mismatches = 0;
  int           cycles = 0;

  tangent_point_from_star_plane_coords_core #(.CORDIC_STEPS(STEPS)) i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .xi(xi), .eta(eta), .star_ra(star_ra), .star_dec(star_dec),
    .done(done), .tp1_ra(tp1_ra), .tp1_dec(tp1_dec), .tp2_ra(tp2_ra),
    .tp2_dec(tp2_dec), .solution_count(solution_count));

  always #5 clk = ~clk;

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res = 0;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic void dec_sin_cos(input longint ang, output longint cs, output longint sn);
    longint x = GAIN;
    longint y = 0;
    longint z = ang;
    longint nx, ny;
    bit flip = 1'b0;
    if (z > QTR || z < -QTR) begin
      z = (z >= 0) ? z - HLF : z + HLF;
      flip = 1'b1;
    end
    for (int i = 0; i < STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - longint'(i < 32 ? ATAN_TAB[i] : 32'h0);
      end else begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + longint'(i < 32 ? ATAN_TAB[i] : 32'h0);
      end
      x = nx;
      y = ny;
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
  endfunction

  function automatic logic [31:0] binary_atan2(input longint yi, input longint xin);
    logic [31:0] z = '0;
    longint x = xin * 65536;
    longint y = yi * 65536;
    longint t, nx, ny;
    if (xin == 0 && yi == 0) return 32'h0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y;
        y = -t;
        z = 32'h40000000;
      end else begin
        x = -y;
        y = t;
        z = 32'hC0000000;
      end
    end
    for (int i = 0; i < STEPS; i++) begin
      if (y > 0) begin
        nx = x + (y >>> i);
        ny = y - (x >>> i);
        z = z + (i < 32 ? ATAN_TAB[i] : 32'h0);
      end else begin
        nx = x - (y >>> i);
        ny = y + (x >>> i);
        z = z - (i < 32 ? ATAN_TAB[i] : 32'h0);
      end
      x = nx;
      y = ny;
    end
    return z;
  endfunction

  function automatic tangent_pts_t solve_tangent_pts(input logic [31:0] xi_b, eta_b, ra_b,
                                                     dec_b);
    tangent_pts_t p;
    longint xs = longint'($signed(xi_b));
    longint es = longint'($signed(eta_b));
    longint cd, sd, sdf, r2, r, rr, s, c;
    longint unsigned xx, yy, x2, y2, c2, s2, root;
    xx = longint'(xs * xs);
    yy = longint'(es * es);
    x2 = xx >> 28;
    y2 = yy >> 28;
    dec_sin_cos(longint'($signed(dec_b)), cd, sd);
    root = floor_root(64'h0100_0000_0000_0000 + xx + yy);
    sdf = (sd * longint'(root)) >>> 30;
    c2 = longint'(cd * cd);
    c2 = c2 >> 32;
    s2 = longint'(sd * sd);
    s2 = s2 >> 32;
    r2 = longint'((c2 * (64'd268435456 + y2)) >> 28) - longint'((s2 * x2) >> 28);
    p = '0;
    if (r2 < 0) return p;
    r = longint'(floor_root(longint'(r2) << 28));
    s = sdf - ((es * r) >>> 28);
    c = ((sdf * es) >>> 28) + r;
    rr = r;
    if (xs == 0 && rr == 0) rr = ONE_Q28;
    p.ra1 = ra_b - binary_atan2(xs, rr);
    p.dec1 = binary_atan2(s, c);
    rr = -rr;
    s = sdf - ((es * rr) >>> 28);
    c = ((sdf * es) >>> 28) + rr;
    p.ra2 = ra_b - binary_atan2(xs, rr);
    p.dec2 = binary_atan2(s, c);
    p.cnt = (sdf < ONE_Q28 && sdf > -ONE_Q28) ? 2'd1 : 2'd2;
    return p;
  endfunction

  always @(posedge clk) begin
    tangent_pts_t want;
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
    if (!rst && start && !busy)
      pending_pts.push_back(cur_known ? cur_pts : solve_tangent_pts(xi, eta, star_ra, star_dec));
    if (!rst && done) begin
      if (pending_pts.size() == 0) begin
        $display("%0t: result beat with nothing expected", $time);
        mismatches <= mismatches + 1;
      end else begin
        want = pending_pts.pop_front();
        if (want.ra1 !== tp1_ra || want.dec1 !== tp1_dec || want.ra2 !== tp2_ra ||
            want.dec2 !== tp2_dec || want.cnt !== solution_count) begin
          $display("%0t: expected tp1 %h/%h tp2 %h/%h count %0d", $time, want.ra1,
                   want.dec1, want.ra2, want.dec2, want.cnt);
          $display("%0t: actual   tp1 %h/%h tp2 %h/%h count %0d", $time, tp1_ra,
                   tp1_dec, tp2_ra, tp2_dec, solution_count);
          mismatches <= mismatches + 1;
        end
      end
    end
  end

  task automatic send_star(input logic [31:0] x, e, ra, d, input logic known,
                           input tangent_pts_t pts, input bit no_gap);
    int gap;
    xi <= x;
    eta <= e;
    star_ra <= ra;
    star_dec <= d;
    cur_known <= known;
    cur_pts <= pts;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    gap = no_gap ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  initial begin
    logic [31:0] x, e, ra, d;
    int kind;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (DIRECTED[k])
      send_star(DIRECTED[k].xi, DIRECTED[k].eta, DIRECTED[k].ra, DIRECTED[k].dec,
                DIRECTED[k].known, DIRECTED[k].pts, 1'b0);
    for (int n = 0; n < N_RANDOM; n++) begin
      kind = $urandom_range(0, 9);
      ra = $urandom;
      d = $urandom;
      if (kind < 6) begin
        x = 32'($signed(20'($urandom)) * 256);
        e = 32'($signed(20'($urandom)) * 256);
      end else if (kind < 8) begin
        x = $urandom;
        e = $urandom;
      end else begin
        x = (kind == 8) ? 32'h0 : 32'($signed(12'($urandom)));
        e = 32'($signed(24'($urandom)));
        d = ($urandom_range(0, 1) ? 32'h40000000 : 32'hC0000000) + 32'($signed(8'($urandom)));
      end
      send_star(x, e, ra, d, 1'b0, NONE, (n / 40) % 3 == 1);
    end
    start <= 1'b0;
    while (pending_pts.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
